/* design/mtg_pkg.sv */
// Shared types, constants and the output tempering function of the MT19937 generator.
// No dependencies; the controller, datapath and top level all use it.
`default_nettype none

package mtg_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned ADDR_W = 10;

	localparam logic [ADDR_W-1:0] WORDS      = 10'd624;
	localparam logic [ADDR_W-1:0] LAST_WORD  = 10'd623;
	localparam logic [ADDR_W-1:0] UNSEEDED   = 10'd625;
	localparam logic [ADDR_W-1:0] SHIFT_OFS  = 10'd397;
	localparam logic [ADDR_W-1:0] WRAP_POINT = 10'd227;

	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
	localparam logic [WORD_W-1:0] LCG_MULT     = 32'd69069;
	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;

	// register byte address of seed_value
	localparam logic [2:0] ADDR_SEED = 3'd0;

	typedef struct packed {
		logic lcg_load;  // start a seed fill from the seed register
		logic seed_wr;   // write one seed word, advance the LCG
		logic tw_prime;  // read word 0, clear the twist counter
		logic tw_rd;     // read next and far words of the current slot
		logic tw_wr;     // write the twisted word, advance
		logic fetch;     // read the word at the read index
		logic deliver;   // temper into the output register, advance index
	} mtg_cmd_t;

	typedef struct packed {
		logic cnt_last;     // fill/twist counter at the last word
		logic idx_unseeded; // state never seeded since reset or seed write
		logic idx_spent;    // all words used, twist needed
		logic out_free;     // output register can take a word this cycle
	} mtg_status_t;

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

/* design/mersenne_twister_generator.sv */
// Top level of the MT19937 pseudo-random word generator: APB seed register,
// controller and datapath. Depends on mtg_pkg, mtg_ctrl and mtg_datapath.
`default_nettype none

// Each accepted item with request set returns one tempered 32-bit MT19937 word on
// random_word; an item with request clear is accepted and dropped. The 624-word
// state sits in a memory with one write and two registered read ports, and every
// step is done by a single sequencer, so the block works on one item at a time.
// A request that finds unused words reads the word (ST_FETCH) and tempers it
// into the output register (ST_LOAD), which waits while that register is held;
// the next item is taken only when the sequencer is back in idle.
// The first request after reset or after a write to seed_value first loads the
// seed, fills all 624 state words from it with the 69069 LCG (one memory write
// a cycle) and then twists it; every 624th request after that twists only.
// The twist runs word by word in place (read neighbor and far word, then write)
// after one priming read. The state memory gets no clearing pass: it is never
// read before being seeded. A finished word waits in the output register while
// the next item is accepted. seed_value sits at byte address 0 and its aliases
// 1 to 3 (the low two bits are not decoded); writes to addresses 4 to 7 are
// ignored and those addresses read back as zero.
module mersenne_twister_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        request,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      random_word,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	mtg_pkg::mtg_cmd_t    cmd;
	mtg_pkg::mtg_status_t status;
	logic                 seed_we;
	logic [31:0]          seed_value;

	// the register takes the write in the access phase; the low two address
	// bits are byte offsets and play no part
	assign pready  = 1'b1;
	assign seed_we = psel && penable && pwrite && pready
	                 && (paddr[2] == mtg_pkg::ADDR_SEED[2]);
	assign prdata  = (paddr[2] == mtg_pkg::ADDR_SEED[2]) ? seed_value : '0;

	mtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.request  (request),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	mtg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.seed_we     (seed_we),
		.seed_wdata  (pwdata),
		.seed_value  (seed_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_word (random_word)
	);

endmodule

`default_nettype wire

/* design/mtg_ctrl.sv */
// Sequencer of the MT19937 generator: seed fill, word-by-word twist, fetch, deliver.
// Depends on mtg_pkg for the command and status structs.
`default_nettype none

module mtg_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               request,
	output logic                    in_stall,
	input  wire mtg_pkg::mtg_status_t status,
	output mtg_pkg::mtg_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_INIT,
		ST_SEED,
		ST_TW_PRIME,
		ST_TW_RD,
		ST_TW_WR,
		ST_FETCH,
		ST_LOAD
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// a request of zero is taken and dropped
					if (in_valid && request) begin
						if (status.idx_unseeded) begin
							state_q <= ST_SEED_INIT;
						end else if (status.idx_spent) begin
							state_q <= ST_TW_PRIME;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_SEED_INIT: state_q <= ST_SEED;
				ST_SEED: begin
					if (status.cnt_last) state_q <= ST_TW_PRIME;
				end
				ST_TW_PRIME: state_q <= ST_TW_RD;
				ST_TW_RD:    state_q <= ST_TW_WR;
				ST_TW_WR: begin
					state_q <= status.cnt_last ? ST_FETCH : ST_TW_RD;
				end
				ST_FETCH:    state_q <= ST_LOAD;
				ST_LOAD: begin
					// hold until the output register frees up
					if (status.out_free) state_q <= ST_IDLE;
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.lcg_load = (state_q == ST_SEED_INIT);
		cmd.seed_wr  = (state_q == ST_SEED);
		cmd.tw_prime = (state_q == ST_TW_PRIME);
		cmd.tw_rd    = (state_q == ST_TW_RD);
		cmd.tw_wr    = (state_q == ST_TW_WR);
		cmd.fetch    = (state_q == ST_FETCH) || (state_q == ST_LOAD);
		cmd.deliver  = (state_q == ST_LOAD) && status.out_free;
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

`default_nettype wire

/* design/mtg_datapath.sv */
// Datapath of the MT19937 generator: 624-word state memory, seed register,
// LCG fill, twist unit, read index and tempered output register. Uses mtg_pkg.
`default_nettype none

module mtg_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mtg_pkg::mtg_cmd_t           cmd,
	output mtg_pkg::mtg_status_t             status,
	input  wire logic                        seed_we,
	input  wire logic [mtg_pkg::WORD_W-1:0]  seed_wdata,
	output logic      [mtg_pkg::WORD_W-1:0]  seed_value,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [mtg_pkg::WORD_W-1:0]  random_word
);

	logic [mtg_pkg::WORD_W-1:0] mem [0:mtg_pkg::WORDS-1];

	logic [mtg_pkg::WORD_W-1:0] seed_q;
	logic [mtg_pkg::WORD_W-1:0] lcg_q;
	logic [mtg_pkg::WORD_W-1:0] cur_q;
	logic [mtg_pkg::WORD_W-1:0] rd_a_q;
	logic [mtg_pkg::WORD_W-1:0] rd_b_q;
	logic [mtg_pkg::WORD_W-1:0] out_q;
	logic                       out_valid_q;
	logic [mtg_pkg::ADDR_W-1:0] cnt_q;
	logic [mtg_pkg::ADDR_W-1:0] idx_q;

	logic [mtg_pkg::ADDR_W-1:0] addr_a;
	logic [mtg_pkg::ADDR_W-1:0] addr_b;
	logic [mtg_pkg::ADDR_W-1:0] nxt_addr;
	logic [mtg_pkg::ADDR_W-1:0] far_addr;
	logic [mtg_pkg::WORD_W-1:0] twist_y;
	logic [mtg_pkg::WORD_W-1:0] twist_v;
	logic [mtg_pkg::WORD_W-1:0] wr_data;
	logic                       mem_we;
	logic                       out_free;

	// neighbor and far slot of the twist recurrence, wrapping at 624
	assign nxt_addr = (cnt_q == mtg_pkg::LAST_WORD) ? '0 : cnt_q + 1'b1;
	assign far_addr = (cnt_q < mtg_pkg::WRAP_POINT) ? cnt_q + mtg_pkg::SHIFT_OFS
	                                                : cnt_q - mtg_pkg::WRAP_POINT;

	always_comb begin
		addr_a = '0;
		addr_b = '0;
		if (cmd.tw_rd) begin
			addr_a = nxt_addr;
			addr_b = far_addr;
		end else if (cmd.fetch) begin
			addr_a = idx_q;
		end
	end

	assign twist_y = {cur_q[mtg_pkg::WORD_W-1], rd_a_q[mtg_pkg::WORD_W-2:0]};
	assign twist_v = rd_b_q ^ (twist_y >> 1) ^ (twist_y[0] ? mtg_pkg::TWIST_MATRIX : '0);
	assign wr_data = cmd.seed_wr ? lcg_q : twist_v;
	assign mem_we  = cmd.seed_wr || cmd.tw_wr;

	always_ff @(posedge clk) begin
		if (mem_we) mem[cnt_q] <= wr_data;
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.lcg_load) begin
			lcg_q <= seed_q;
		end else if (cmd.seed_wr) begin
			lcg_q <= lcg_q * mtg_pkg::LCG_MULT;
		end
		// word 0 comes from the priming read; later words from the previous nxt read
		if (cmd.tw_rd && (cnt_q == '0)) begin
			cur_q <= rd_a_q;
		end else if (cmd.tw_wr) begin
			cur_q <= rd_a_q;
		end
		if (cmd.deliver) out_q <= mtg_pkg::temper(rd_a_q);
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= mtg_pkg::DEFAULT_SEED;
			idx_q       <= mtg_pkg::UNSEEDED;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_we) begin
				seed_q <= seed_wdata;
				idx_q  <= mtg_pkg::UNSEEDED;
			end else if (cmd.tw_wr && (cnt_q == mtg_pkg::LAST_WORD)) begin
				idx_q <= '0;
			end else if (cmd.deliver) begin
				idx_q <= idx_q + 1'b1;
			end

			if (cmd.lcg_load || cmd.tw_prime) begin
				cnt_q <= '0;
			end else if (cmd.seed_wr || cmd.tw_wr) begin
				cnt_q <= (cnt_q == mtg_pkg::LAST_WORD) ? '0 : cnt_q + 1'b1;
			end

			if (cmd.deliver) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status              = '0;
		status.cnt_last     = (cnt_q == mtg_pkg::LAST_WORD);
		status.idx_unseeded = (idx_q == mtg_pkg::UNSEEDED);
		status.idx_spent    = (idx_q >= mtg_pkg::WORDS);
		status.out_free     = out_free;
	end

	assign seed_value  = seed_q;
	assign out_valid   = out_valid_q;
	assign random_word = out_q;

endmodule

`default_nettype wire

/* design/mtg_checker.sv */
// Port-level checks of the MT19937 generator, bound to the top level.
// Sees the top-level ports only; no package dependency.
`default_nettype none

module mtg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        request,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] random_word,
	input wire logic        pready
);

	// a held result keeps its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(random_word))
		else $error("result item changed while stalled");

	// a real request keeps the block busy on the next cycle
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && request |=> in_stall)
		else $error("request item accepted without going busy");

	// a new result only appears as the sequencer finishes an item
	a_out_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $fell(in_stall))
		else $error("result item appeared without a finished request");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("configuration port not ready");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.request     (request),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.random_word (random_word),
	.pready      (pready)
);

`default_nettype wire
